FILE: sv/clss_pkg.sv
// -----------------------------------------------------------------------------
// clss_pkg
// Shared types, constants and helpers of the closed-loop stimulus sequencer.
// -----------------------------------------------------------------------------
package clss_pkg;

   // Default sizing
   localparam int unsigned TABLE_DEPTH_DEFAULT   = 4096;
   localparam int unsigned CHANNEL_COUNT_DEFAULT = 8;

   // Payload widths
   localparam int unsigned OPCODE_W  = 2;
   localparam int unsigned FLAGS_W   = 32;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TINDEX_W  = 12;
   localparam int unsigned RECORD_W  = 64;
   localparam int unsigned TICKS_W   = 16;
   localparam int unsigned HIST_W    = 64;
   localparam int unsigned LENGTH_W  = 13;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_TICKS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_VALUE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_SELECT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MODE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIEF_LENGTH   = 3'd4;

   localparam logic [TICKS_W-1:0] BIN_TICKS_RESET     = 16'd1;
   localparam logic [HIST_W-1:0]  PATTERN_VALUE_RESET = 64'h0000_0000_0000_00ff;

   // Operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_EVENT    = 2'd0,
      OP_TABLE_WR = 2'd1,
      OP_START    = 2'd2
   } opcode_type;

   // Flag word
   localparam logic [FLAGS_W-1:0] FLAG_NOT_OURS = 32'h8000_0000;
   localparam int unsigned        REFRESH_BIT   = 8;
   localparam int unsigned        SPIKE_BIT     = 0;

   // Zigzag stimulus
   localparam logic [BYTE_W-1:0] STIM_RESET = 8'h18;
   localparam logic [BYTE_W-1:0] ZIG_BOTTOM = 8'h01;
   localparam logic [BYTE_W-1:0] ZIG_TOP    = 8'h80;
   localparam logic [BYTE_W-1:0] ZIG_LOW    = 8'h03;
   localparam logic [BYTE_W-1:0] ZIG_HIGH   = 8'hc0;

   // What an event carries from the control stage to the stimulus stage
   typedef struct packed {
      logic                claimed;
      logic [RECORD_W-1:0] record;
      logic                refresh;
      logic                use_table;
      logic                long_mode;
      logic                stream_valid;
      logic [BYTE_W-1:0]   stream_byte;
   } evt_type;

   // Table index modulo depth: at most eight conditional subtracts of the
   // shifted depth (quotient fits eight bits since depth >= 16).
   function automatic logic [TINDEX_W-1:0] index_mod(input logic [TINDEX_W-1:0] x,
                                                     input int unsigned depth);
      logic [23:0] r;
      r = {12'b0, x};
      for (int k = 7; k >= 0; k--) begin
         if (r >= (24'(depth) << k)) begin
            r = r - (24'(depth) << k);
         end
      end
      return r[TINDEX_W-1:0];
   endfunction

endpackage

FILE: sv/clss_req_if.sv
// -----------------------------------------------------------------------------
// clss_req_if
// Request channel: event, table write and start transactions.
// -----------------------------------------------------------------------------
interface clss_req_if;
   logic                               valid;
   logic                               ready;
   logic [clss_pkg::OPCODE_W-1:0]      opcode;
   logic [clss_pkg::FLAGS_W-1:0]       channel_flags;
   logic [clss_pkg::TIME_W-1:0]        event_time;
   logic [clss_pkg::BYTE_W-1:0]        stream_byte;
   logic                               stream_valid;
   logic [clss_pkg::TINDEX_W-1:0]      table_index;
   logic [clss_pkg::BYTE_W-1:0]        table_byte;

   modport source (
      output valid, opcode, channel_flags, event_time, stream_byte, stream_valid,
             table_index, table_byte,
      input  ready
   );
   modport sink (
      input  valid, opcode, channel_flags, event_time, stream_byte, stream_valid,
             table_index, table_byte,
      output ready
   );
endinterface

FILE: sv/clss_rsp_if.sv
// -----------------------------------------------------------------------------
// clss_rsp_if
// Response channel: one transaction per acquisition event.
// -----------------------------------------------------------------------------
interface clss_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               claimed;
   logic [clss_pkg::RECORD_W-1:0]      record;
   logic [clss_pkg::BYTE_W-1:0]        stim_out;
   logic                               stim_written;

   modport source (
      output valid, claimed, record, stim_out, stim_written,
      input  ready
   );
   modport sink (
      input  valid, claimed, record, stim_out, stim_written,
      output ready
   );
endinterface

FILE: sv/clss_table.sv
// -----------------------------------------------------------------------------
// clss_table
// Brief stimulus table: one write port, one registered read port.
// -----------------------------------------------------------------------------
module clss_table #(
   parameter int unsigned DEPTH = clss_pkg::TABLE_DEPTH_DEFAULT,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [clss_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [clss_pkg::BYTE_W-1:0] rd_data
);

   logic [clss_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [clss_pkg::BYTE_W-1:0] rd_data_ff;

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/clss_ctrl.sv
// -----------------------------------------------------------------------------
// clss_ctrl
// Control stage: configuration, tick/bin history, brief playback state,
// table access and the stage register toward the stimulus stage.
// -----------------------------------------------------------------------------
module clss_ctrl #(
   parameter int unsigned TABLE_DEPTH   = clss_pkg::TABLE_DEPTH_DEFAULT,
   parameter int unsigned CHANNEL_COUNT = clss_pkg::CHANNEL_COUNT_DEFAULT,
   localparam int unsigned AW           = $clog2(TABLE_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   clss_req_if.sink                         req_ch,
   input  logic                             csr_we,
   input  logic [clss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             s2_take,
   output logic                             s1_valid,
   output clss_pkg::evt_type                s1_evt,
   output logic                             tbl_wr_en,
   output logic [AW-1:0]                    tbl_wr_addr,
   output logic [clss_pkg::BYTE_W-1:0]      tbl_wr_data,
   output logic                             tbl_rd_en,
   output logic [AW-1:0]                    tbl_rd_addr
);

   localparam int unsigned TagBit = CHANNEL_COUNT + 1;

   // Configuration
   logic [clss_pkg::TICKS_W-1:0]  bin_ticks_ff, bin_ticks_in;
   logic [clss_pkg::HIST_W-1:0]   pattern_value_ff, pattern_value_in;
   logic [clss_pkg::HIST_W-1:0]   pattern_select_ff, pattern_select_in;
   logic                          long_mode_ff, long_mode_in;
   logic [clss_pkg::LENGTH_W-1:0] brief_length_ff, brief_length_in;

   // Sequencer state
   logic [clss_pkg::HIST_W-1:0]   history_ff, history_in;
   logic [clss_pkg::TICKS_W-1:0]  tick_count_ff, tick_count_in;
   logic                          spike_seen_ff, spike_seen_in;
   logic                          brief_active_ff, brief_active_in;
   logic [clss_pkg::LENGTH_W-1:0] play_pos_ff, play_pos_in;

   // Stage register
   logic                          s1_valid_ff, s1_valid_in;
   clss_pkg::evt_type             evt_ff, evt_in;

   // Event datapath
   logic                          accept;
   logic [clss_pkg::FLAGS_W-1:0]  tag_flags;
   logic                          not_ours;
   logic                          refresh;
   logic                          spike;
   logic [clss_pkg::TICKS_W-1:0]  tick_next;
   logic                          close_bin;
   logic [clss_pkg::HIST_W-1:0]   history_shift;
   logic                          match;
   logic                          brief_now;
   logic [clss_pkg::LENGTH_W-1:0] pos_now;
   logic [clss_pkg::LENGTH_W-1:0] pos_next;
   logic [clss_pkg::LENGTH_W-1:0] length_wr;

   assign req_ch.ready = !s1_valid_ff || s2_take;
   assign accept       = req_ch.valid && req_ch.ready;

   assign tag_flags = req_ch.channel_flags
                    | (clss_pkg::FLAGS_W'(brief_active_ff) << TagBit);
   assign not_ours  = (req_ch.channel_flags == clss_pkg::FLAG_NOT_OURS);
   assign refresh   = tag_flags[clss_pkg::REFRESH_BIT];
   assign spike     = tag_flags[clss_pkg::SPIKE_BIT];

   assign tick_next     = tick_count_ff + 1'b1;
   assign close_bin     = (tick_next >= bin_ticks_ff);
   assign history_shift = {history_ff[clss_pkg::HIST_W-2:0], spike_seen_ff};
   assign match         = close_bin && !brief_active_ff
                       && ((history_shift & pattern_select_ff) == pattern_value_ff);
   assign brief_now     = brief_active_ff || match;
   assign pos_now       = match ? '0 : play_pos_ff;
   assign pos_next      = pos_now + 1'b1;

   // Clamp a written length to the table depth
   assign length_wr = (32'(csr_wdata[clss_pkg::LENGTH_W-1:0]) > 32'(TABLE_DEPTH))
                    ? clss_pkg::LENGTH_W'(TABLE_DEPTH)
                    : csr_wdata[clss_pkg::LENGTH_W-1:0];

   always_comb begin
      bin_ticks_in      = bin_ticks_ff;
      pattern_value_in  = pattern_value_ff;
      pattern_select_in = pattern_select_ff;
      long_mode_in      = long_mode_ff;
      brief_length_in   = brief_length_ff;
      history_in        = history_ff;
      tick_count_in     = tick_count_ff;
      spike_seen_in     = spike_seen_ff;
      brief_active_in   = brief_active_ff;
      play_pos_in       = play_pos_ff;
      s1_valid_in       = s1_valid_ff && !s2_take;
      evt_in            = evt_ff;
      tbl_wr_en         = 1'b0;
      tbl_wr_addr       = AW'(clss_pkg::index_mod(req_ch.table_index, TABLE_DEPTH));
      tbl_wr_data       = req_ch.table_byte;
      tbl_rd_en         = 1'b0;
      // play position stays below the depth while playback is active
      tbl_rd_addr       = AW'(pos_now);

      if (csr_we) begin
         unique case (csr_index)
            clss_pkg::CSR_BIN_TICKS:      bin_ticks_in = csr_wdata[clss_pkg::TICKS_W-1:0];
            clss_pkg::CSR_PATTERN_VALUE:  pattern_value_in = csr_wdata;
            clss_pkg::CSR_PATTERN_SELECT: pattern_select_in = csr_wdata;
            clss_pkg::CSR_LONG_MODE:      long_mode_in = csr_wdata[0];
            clss_pkg::CSR_BRIEF_LENGTH: begin
               brief_length_in = length_wr;
               play_pos_in     = '0;
            end
            default: ;
         endcase
      end else if (accept) begin
         unique case (req_ch.opcode)
            clss_pkg::OP_TABLE_WR: begin
               tbl_wr_en = 1'b1;
            end
            clss_pkg::OP_START: begin
               brief_active_in = 1'b0;
            end
            clss_pkg::OP_EVENT: begin
               s1_valid_in = 1'b1;
               if (not_ours) begin
                  evt_in = '0;
               end else begin
                  evt_in.claimed      = 1'b1;
                  evt_in.record       = {req_ch.event_time, tag_flags};
                  evt_in.refresh      = refresh;
                  evt_in.use_table    = refresh && brief_now;
                  evt_in.long_mode    = long_mode_ff;
                  evt_in.stream_valid = req_ch.stream_valid;
                  evt_in.stream_byte  = req_ch.stream_byte;
                  if (refresh) begin
                     if (close_bin) begin
                        history_in    = history_shift;
                        tick_count_in = '0;
                        spike_seen_in = 1'b0;
                     end else begin
                        tick_count_in = tick_next;
                     end
                     if (brief_now) begin
                        tbl_rd_en   = 1'b1;
                        play_pos_in = pos_next;
                        brief_active_in = (pos_next < brief_length_ff);
                     end else begin
                        play_pos_in     = pos_now;
                        brief_active_in = brief_now && (pos_now < brief_length_ff);
                     end
                  end
                  if (spike) begin
                     spike_seen_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ticks_ff      <= clss_pkg::BIN_TICKS_RESET;
         pattern_value_ff  <= clss_pkg::PATTERN_VALUE_RESET;
         pattern_select_ff <= '0;
         long_mode_ff      <= 1'b0;
         brief_length_ff   <= '0;
         history_ff        <= '0;
         tick_count_ff     <= '0;
         spike_seen_ff     <= 1'b0;
         brief_active_ff   <= 1'b0;
         play_pos_ff       <= '0;
         s1_valid_ff       <= 1'b0;
      end else begin
         bin_ticks_ff      <= bin_ticks_in;
         pattern_value_ff  <= pattern_value_in;
         pattern_select_ff <= pattern_select_in;
         long_mode_ff      <= long_mode_in;
         brief_length_ff   <= brief_length_in;
         history_ff        <= history_in;
         tick_count_ff     <= tick_count_in;
         spike_seen_ff     <= spike_seen_in;
         brief_active_ff   <= brief_active_in;
         play_pos_ff       <= play_pos_in;
         s1_valid_ff       <= s1_valid_in;
      end
      evt_ff <= evt_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_evt   = evt_ff;

endmodule

FILE: sv/clss_stim.sv
// -----------------------------------------------------------------------------
// clss_stim
// Stimulus stage: merges table read data, stream byte or zigzag step into
// the current stimulus and holds the response register.
// -----------------------------------------------------------------------------
module clss_stim (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        s1_valid,
   input  clss_pkg::evt_type           s1_evt,
   input  logic [clss_pkg::BYTE_W-1:0] tbl_rd_data,
   output logic                        s2_take,
   clss_rsp_if.source                  rsp_ch
);

   logic [clss_pkg::BYTE_W-1:0]   stim_ff, stim_in;
   logic                          zig_up_ff, zig_up_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          claimed_ff, claimed_in;
   logic [clss_pkg::RECORD_W-1:0] record_ff, record_in;
   logic [clss_pkg::BYTE_W-1:0]   stim_out_ff, stim_out_in;
   logic                          written_ff, written_in;

   logic [clss_pkg::BYTE_W-1:0]   zig_shift;
   logic [clss_pkg::BYTE_W-1:0]   zig_stim;
   logic                          zig_dir;
   logic [clss_pkg::BYTE_W-1:0]   new_stim;
   logic                          new_dir;
   logic                          advance;

   assign s2_take = !out_valid_ff || rsp_ch.ready;
   assign advance = s1_valid && s2_take;

   // Zigzag step: bounce at the ends
   assign zig_shift = zig_up_ff ? {stim_ff[clss_pkg::BYTE_W-2:0], 1'b0}
                                : {1'b0, stim_ff[clss_pkg::BYTE_W-1:1]};
   always_comb begin
      zig_stim = zig_shift;
      zig_dir  = zig_up_ff;
      if (zig_shift == clss_pkg::ZIG_BOTTOM) begin
         zig_stim = clss_pkg::ZIG_LOW;
         zig_dir  = 1'b1;
      end else if (zig_shift == clss_pkg::ZIG_TOP) begin
         zig_stim = clss_pkg::ZIG_HIGH;
         zig_dir  = 1'b0;
      end
   end

   always_comb begin
      new_stim = stim_ff;
      new_dir  = zig_up_ff;
      if (s1_evt.use_table) begin
         new_stim = tbl_rd_data;
      end else if (s1_evt.long_mode) begin
         if (s1_evt.stream_valid) begin
            new_stim = s1_evt.stream_byte;
         end
      end else begin
         new_stim = zig_stim;
         new_dir  = zig_dir;
      end
   end

   always_comb begin
      stim_in      = stim_ff;
      zig_up_in    = zig_up_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      claimed_in   = claimed_ff;
      record_in    = record_ff;
      stim_out_in  = stim_out_ff;
      written_in   = written_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         claimed_in   = s1_evt.claimed;
         record_in    = s1_evt.record;
         written_in   = s1_evt.refresh;
         stim_out_in  = '0;
         if (s1_evt.refresh) begin
            stim_in     = new_stim;
            zig_up_in   = new_dir;
            stim_out_in = new_stim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stim_ff      <= clss_pkg::STIM_RESET;
         zig_up_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stim_ff      <= stim_in;
         zig_up_ff    <= zig_up_in;
         out_valid_ff <= out_valid_in;
      end
      claimed_ff  <= claimed_in;
      record_ff   <= record_in;
      stim_out_ff <= stim_out_in;
      written_ff  <= written_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.claimed      = claimed_ff;
   assign rsp_ch.record       = record_ff;
   assign rsp_ch.stim_out     = stim_out_ff;
   assign rsp_ch.stim_written = written_ff;

endmodule

FILE: sv/closed_loop_stimulus_sequencer_unit.sv
// -----------------------------------------------------------------------------
// closed_loop_stimulus_sequencer_unit
// Acquisition event tagging, spike binning, pattern-triggered table playback.
// -----------------------------------------------------------------------------
// Path: an accepted event passes the control stage register, then its table
//   read data is merged into the response register.
// Throughput: one transaction per cycle while the response channel is not
//   stalled; the table memory takes at most one access per transaction
//   and the stimulus state updates at most once per cycle.
// Reset: synchronous; clears sequencer state and loads register defaults.
//   Table contents are undefined until written.
module closed_loop_stimulus_sequencer_unit #(
   parameter int unsigned TABLE_DEPTH   = clss_pkg::TABLE_DEPTH_DEFAULT,
   parameter int unsigned CHANNEL_COUNT = clss_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   clss_req_if.sink                         req_ch,
   clss_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [clss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   logic                        s1_valid;
   clss_pkg::evt_type           s1_evt;
   logic                        s2_take;
   logic                        tbl_wr_en;
   logic [AW-1:0]               tbl_wr_addr;
   logic [clss_pkg::BYTE_W-1:0] tbl_wr_data;
   logic                        tbl_rd_en;
   logic [AW-1:0]               tbl_rd_addr;
   logic [clss_pkg::BYTE_W-1:0] tbl_rd_data;

   clss_ctrl #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .s2_take     (s2_take),
      .s1_valid    (s1_valid),
      .s1_evt      (s1_evt),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr)
   );

   clss_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   clss_stim u_stim (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_evt      (s1_evt),
      .tbl_rd_data (tbl_rd_data),
      .s2_take     (s2_take),
      .rsp_ch      (rsp_ch)
   );

endmodule

FILE: sv/clss_checker.sv
// -----------------------------------------------------------------------------
// clss_checker
// Port-level checks on the response channel of the sequencer.
// -----------------------------------------------------------------------------
module clss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_claimed,
   input logic [clss_pkg::RECORD_W-1:0] rsp_record,
   input logic [clss_pkg::BYTE_W-1:0]   rsp_stim_out,
   input logic                          rsp_stim_written
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record)
         && $stable(rsp_claimed) && $stable(rsp_stim_out) && $stable(rsp_stim_written))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_unclaimed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_claimed |-> rsp_record == '0 && rsp_stim_out == '0
         && !rsp_stim_written)
      else $error("unclaimed event carries data");

   a_stim_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stim_written |-> rsp_stim_out == '0)
      else $error("stimulus shown without a write");

   a_claimed_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_claimed |-> rsp_record[31:0] != clss_pkg::FLAG_NOT_OURS)
      else $error("claimed record holds the foreign flag word");

endmodule

bind closed_loop_stimulus_sequencer_unit clss_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_claimed      (rsp_ch.claimed),
   .rsp_record       (rsp_ch.record),
   .rsp_stim_out     (rsp_ch.stim_out),
   .rsp_stim_written (rsp_ch.stim_written)
);
